@@ rtl/cqm_pkg.sv @@
// cdf quantile mapper shared definitions: op codes, status codes, register indexes
// and the status bundle from datapath to controller. no dependencies.
`timescale 1ns / 1ps
package cqm_pkg;
	localparam int DEPTH_DEFAULT = 1024;

	localparam logic [2:0] REG_GRID_LOW    = 3'd0;
	localparam logic [2:0] REG_GRID_HIGH   = 3'd1;
	localparam logic [2:0] REG_INV_STEP    = 3'd2;
	localparam logic [2:0] REG_POINTS_USED = 3'd3;
	localparam logic [2:0] REG_TABLE_VALID = 3'd4;

	localparam logic [1:0] ST_MAPPED = 2'd0;
	localparam logic [1:0] ST_FAIL   = 2'd1;
	localparam logic [1:0] ST_LOADED = 2'd2;

	localparam logic [16:0] ONE_Q16 = 17'd65536;

	typedef logic [4:0] op_t;
	localparam op_t OP_NONE      = 5'd0;
	localparam op_t OP_ACCEPT    = 5'd1;
	localparam op_t OP_MUL       = 5'd2;
	localparam op_t OP_SRC_A     = 5'd3;
	localparam op_t OP_SRC_B     = 5'd4;
	localparam op_t OP_SRC_M     = 5'd5;
	localparam op_t OP_SRC_C     = 5'd6;
	localparam op_t OP_SRCH_RD   = 5'd7;
	localparam op_t OP_SRCH_CMP  = 5'd8;
	localparam op_t OP_FIN_A     = 5'd9;
	localparam op_t OP_FIN_B     = 5'd10;
	localparam op_t OP_FIN_C     = 5'd11;
	localparam op_t OP_DIV_INIT  = 5'd12;
	localparam op_t OP_DIV       = 5'd13;
	localparam op_t OP_BL_MUL    = 5'd14;
	localparam op_t OP_RES_LOAD  = 5'd15;
	localparam op_t OP_RES_FAIL  = 5'd16;
	localparam op_t OP_RES_HIGH  = 5'd17;
	localparam op_t OP_RES_LOW   = 5'd18;
	localparam op_t OP_RES_G0    = 5'd19;
	localparam op_t OP_RES_BLEND = 5'd20;

	typedef struct packed {
		logic is_load;
		logic early_fail;
		logic c_bad;
		logic srch_done;
		logic k_ge_n;
		logic k_zero;
		logic den_bad;
		logic div_clamp;
		logic div_last;
	} dp_stat_t;
endpackage

@@ rtl/cqm_ctrl.sv @@
// cdf quantile mapper controller: sequences load and map words through the datapath
// depends on cqm_pkg
`timescale 1ns / 1ps
module cqm_ctrl
	import cqm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  dp_stat_t stat,
	output logic     busy,
	output op_t      op
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DISP = 4'd1;
	localparam logic [3:0] S_SRCA = 4'd2;
	localparam logic [3:0] S_SRCB = 4'd3;
	localparam logic [3:0] S_SRCM = 4'd4;
	localparam logic [3:0] S_SRCC = 4'd5;
	localparam logic [3:0] S_SRD  = 4'd6;
	localparam logic [3:0] S_SCMP = 4'd7;
	localparam logic [3:0] S_FINB = 4'd8;
	localparam logic [3:0] S_FINC = 4'd9;
	localparam logic [3:0] S_FIND = 4'd10;
	localparam logic [3:0] S_DIV  = 4'd11;
	localparam logic [3:0] S_BMUL = 4'd12;
	localparam logic [3:0] S_BRES = 4'd13;

	logic [3:0] state_q, state_nx;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_nx = state_q;
		op = OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					op = OP_ACCEPT;
					state_nx = S_DISP;
				end
			end
			S_DISP: begin
				if (stat.is_load) begin
					op = OP_RES_LOAD;
					state_nx = S_IDLE;
				end else if (stat.early_fail) begin
					op = OP_RES_FAIL;
					state_nx = S_IDLE;
				end else begin
					op = OP_MUL;
					state_nx = S_SRCA;
				end
			end
			S_SRCA: begin
				op = OP_SRC_A;
				state_nx = S_SRCB;
			end
			S_SRCB: begin
				op = OP_SRC_B;
				state_nx = S_SRCM;
			end
			S_SRCM: begin
				op = OP_SRC_M;
				state_nx = S_SRCC;
			end
			S_SRCC: begin
				op = OP_SRC_C;
				state_nx = S_SRD;
			end
			S_SRD: begin
				if (stat.c_bad) begin
					op = OP_RES_FAIL;
					state_nx = S_IDLE;
				end else if (stat.srch_done) begin
					if (stat.k_ge_n) begin
						op = OP_RES_HIGH;
						state_nx = S_IDLE;
					end else if (stat.k_zero) begin
						op = OP_RES_LOW;
						state_nx = S_IDLE;
					end else begin
						op = OP_FIN_A;
						state_nx = S_FINB;
					end
				end else begin
					op = OP_SRCH_RD;
					state_nx = S_SCMP;
				end
			end
			S_SCMP: begin
				op = OP_SRCH_CMP;
				state_nx = S_SRD;
			end
			S_FINB: begin
				op = OP_FIN_B;
				state_nx = S_FINC;
			end
			S_FINC: begin
				op = OP_FIN_C;
				state_nx = S_FIND;
			end
			S_FIND: begin
				if (stat.den_bad) begin
					op = OP_RES_G0;
					state_nx = S_IDLE;
				end else begin
					op = OP_DIV_INIT;
					state_nx = stat.div_clamp ? S_BMUL : S_DIV;
				end
			end
			S_DIV: begin
				op = OP_DIV;
				if (stat.div_last) state_nx = S_BMUL;
			end
			S_BMUL: begin
				op = OP_BL_MUL;
				state_nx = S_BRES;
			end
			S_BRES: begin
				op = OP_RES_BLEND;
				state_nx = S_IDLE;
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end
endmodule

@@ rtl/cqm_dpath.sv @@
// cdf quantile mapper datapath: config registers, the three tables, multiplier,
// binary search registers and the radix-2 fraction divider. depends on cqm_pkg
`timescale 1ns / 1ps
module cqm_dpath
	import cqm_pkg::*;
#(
	parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  op_t         op,
	output dp_stat_t    stat,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        req_type,
	input  logic [9:0]  entry_index,
	input  logic signed [31:0] entry_value,
	input  logic [16:0] entry_target_cdf,
	input  logic [16:0] entry_source_cdf,
	input  logic signed [31:0] sample_value,
	output logic        done,
	output logic signed [31:0] mapped_value,
	output logic [1:0]  status
);
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = AW + 1;

	logic signed [31:0] grid_low_q, grid_high_q;
	logic [31:0] inv_step_q;
	logic [10:0] points_used_q;
	logic        table_valid_q;

	logic [31:0] grid_mem [TABLE_DEPTH];
	logic [16:0] tgt_mem  [TABLE_DEPTH];
	logic [16:0] src_mem  [TABLE_DEPTH];
	logic [31:0] grid_rd;
	logic [16:0] tgt_rd, src_rd;
	logic [AW-1:0] rd_addr;
	logic        mem_we;

	logic        req_q;
	logic signed [31:0] sample_q;
	logic [CW-1:0] n_q, lo_q, hi_q, mid_q;
	logic [63:0] p_q;
	logic [16:0] c0_q, c_q, t0_q, t1_q, den_q;
	logic [31:0] g0_q, g1_q;
	logic signed [50:0] prod_q;
	logic [17:0] rem_q;
	logic [16:0] g_q;
	logic [4:0]  cnt_q;
	logic        done_q;
	logic signed [31:0] mapped_q;
	logic [1:0]  status_q;

	logic [31:0] pu_w, n_sel;
	logic signed [32:0] diff33;
	logic        ip_past;
	logic [CW-1:0] mid;
	logic [16:0] x_num, den_w;
	logic [17:0] r2;
	logic signed [17:0] dc, fs;
	logic signed [18:0] c_full;
	logic signed [32:0] gd;
	logic [31:0] blend;

	// config word port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_low_q <= '0;
			grid_high_q <= '0;
			inv_step_q <= '0;
			points_used_q <= 11'd2;
			table_valid_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GRID_LOW: grid_low_q <= cfg_data;
				REG_GRID_HIGH: grid_high_q <= cfg_data;
				REG_INV_STEP: inv_step_q <= cfg_data;
				REG_POINTS_USED: points_used_q <= cfg_data[10:0];
				REG_TABLE_VALID: table_valid_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign pu_w = 32'(points_used_q);
	assign n_sel = (pu_w < 32'd2) ? 32'd2 :
		(pu_w > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : pu_w;
	assign diff33 = 33'(sample_q) - 33'(grid_low_q);
	assign ip_past = (p_q[63:32] >= 32'(n_q - CW'(1)));
	assign mid = lo_q + ((hi_q - lo_q) >> 1);
	assign x_num = c_q - t0_q;
	assign den_w = t1_q - t0_q;
	assign r2 = {rem_q[16:0], 1'b0};
	assign dc = $signed({1'b0, src_rd}) - $signed({1'b0, c0_q});
	assign fs = $signed({2'b00, p_q[31:16]});
	assign c_full = $signed({2'b00, c0_q}) + 19'(prod_q >>> 16);
	assign gd = 33'(signed'(g1_q)) - 33'(signed'(g0_q));
	assign blend = g0_q + 32'(prod_q >>> 16);

	assign stat.is_load = !req_q;
	assign stat.early_fail = !table_valid_q || (sample_q < grid_low_q) ||
		(sample_q > grid_high_q);
	assign stat.c_bad = (c_q > ONE_Q16);
	assign stat.srch_done = (lo_q >= hi_q);
	assign stat.k_ge_n = (lo_q >= n_q);
	assign stat.k_zero = (lo_q == '0);
	assign stat.den_bad = (t1_q <= t0_q) || (c_q < t0_q);
	assign stat.div_clamp = (x_num >= den_w);
	assign stat.div_last = (cnt_q == 5'd1);

	// tables, one shared read address with registered read data
	assign mem_we = (op == OP_ACCEPT) && !req_type && (32'(entry_index) < 32'(TABLE_DEPTH));

	always_comb begin
		rd_addr = '0;
		case (op)
			OP_SRC_A: rd_addr = ip_past ? AW'(n_q - CW'(1)) : AW'(p_q[63:32]);
			OP_SRC_B: rd_addr = AW'(p_q[63:32]) + AW'(1);
			OP_SRCH_RD: rd_addr = AW'(mid);
			OP_FIN_A: rd_addr = AW'(lo_q - CW'(1));
			OP_FIN_B: rd_addr = AW'(lo_q);
			default: rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			grid_mem[AW'(entry_index)] <= entry_value;
			tgt_mem[AW'(entry_index)] <= entry_target_cdf;
			src_mem[AW'(entry_index)] <= entry_source_cdf;
		end
		grid_rd <= grid_mem[rd_addr];
		tgt_rd <= tgt_mem[rd_addr];
		src_rd <= src_mem[rd_addr];
	end

	// working registers
	always_ff @(posedge clk) begin
		case (op)
			OP_ACCEPT: begin
				sample_q <= sample_value;
				n_q <= CW'(n_sel);
			end
			OP_MUL: p_q <= 64'(diff33[31:0]) * 64'(inv_step_q);
			OP_SRC_B: c0_q <= src_rd;
			OP_SRC_M: prod_q <= 51'(dc * fs);
			OP_SRC_C: begin
				c_q <= ip_past ? c0_q : 17'(c_full);
				lo_q <= '0;
				hi_q <= n_q;
			end
			OP_SRCH_RD: mid_q <= mid;
			OP_SRCH_CMP: begin
				if (tgt_rd < c_q) lo_q <= mid_q + CW'(1);
				else hi_q <= mid_q;
			end
			OP_FIN_B: begin
				t0_q <= tgt_rd;
				g0_q <= grid_rd;
			end
			OP_FIN_C: begin
				t1_q <= tgt_rd;
				g1_q <= grid_rd;
			end
			OP_DIV_INIT: begin
				den_q <= den_w;
				rem_q <= {1'b0, x_num};
				cnt_q <= 5'd16;
				g_q <= stat.div_clamp ? ONE_Q16 : 17'd0;
			end
			OP_DIV: begin
				// restoring step, one quotient bit per cycle
				if (r2 >= {1'b0, den_q}) begin
					rem_q <= r2 - {1'b0, den_q};
					g_q <= {g_q[15:0], 1'b1};
				end else begin
					rem_q <= r2;
					g_q <= {g_q[15:0], 1'b0};
				end
				cnt_q <= cnt_q - 5'd1;
			end
			OP_BL_MUL: prod_q <= 51'(gd * $signed({1'b0, g_q}));
			default: ;
		endcase
	end

	// result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			req_q <= 1'b0;
		end else begin
			if (op == OP_ACCEPT) req_q <= req_type;
			done_q <= (op == OP_RES_LOAD) || (op == OP_RES_FAIL) || (op == OP_RES_HIGH) ||
				(op == OP_RES_LOW) || (op == OP_RES_G0) || (op == OP_RES_BLEND);
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_RES_LOAD: begin
				mapped_q <= '0;
				status_q <= ST_LOADED;
			end
			OP_RES_FAIL: begin
				mapped_q <= '0;
				status_q <= ST_FAIL;
			end
			OP_RES_HIGH: begin
				mapped_q <= grid_high_q;
				status_q <= ST_MAPPED;
			end
			OP_RES_LOW: begin
				mapped_q <= grid_low_q;
				status_q <= ST_MAPPED;
			end
			OP_RES_G0: begin
				mapped_q <= g0_q;
				status_q <= ST_MAPPED;
			end
			OP_RES_BLEND: begin
				mapped_q <= blend;
				status_q <= ST_MAPPED;
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign mapped_value = mapped_q;
	assign status = status_q;
endmodule

@@ rtl/cdf_quantile_mapper.sv @@
// cdf quantile mapper top level: controller plus datapath
// depends on cqm_pkg, cqm_ctrl, cqm_dpath
// sequence: a load word writes the tables; a map word runs a binary search over the points
// through the single table read port and then, where needed, a restoring fraction divider
// throughput: one word at a time; busy falls as the result strobe rises
// reset: asynchronous, resets control and config registers; tables are not cleared
// results are shown for one cycle on done; the receiver cannot stall
`timescale 1ns / 1ps
module cdf_quantile_mapper
	import cqm_pkg::*;
#(
	parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [9:0]  entry_index,
	input  logic signed [31:0] entry_value,
	input  logic [16:0] entry_target_cdf,
	input  logic [16:0] entry_source_cdf,
	input  logic signed [31:0] sample_value,
	output logic        done,
	output logic signed [31:0] mapped_value,
	output logic [1:0]  status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	op_t      op;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	cqm_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.stat(stat),
		.busy(busy),
		.op(op)
	);

	cqm_dpath #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.op(op),
		.stat(stat),
		.cfg_we(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req_type(req_type),
		.entry_index(entry_index),
		.entry_value(entry_value),
		.entry_target_cdf(entry_target_cdf),
		.entry_source_cdf(entry_source_cdf),
		.sample_value(sample_value),
		.done(done),
		.mapped_value(mapped_value),
		.status(status)
	);

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without a word in flight");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted word did not raise busy");
	a_zero_unmapped: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_MAPPED |-> mapped_value == 32'sd0)
		else $error("nonzero value on failed or load result");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> status == ST_MAPPED || status == ST_FAIL || status == ST_LOADED)
		else $error("bad status code");
endmodule
